// ===== design/tbim_pkg.sv =====
// Shared types, widths and register codes for the track best-IoU match update block.
package tbim_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_W        = 16;
	localparam int FRAME_W        = 32;
	localparam int VEL_W          = 27;
	localparam int THR_W          = 16;
	localparam int LIMIT_W        = 16;
	localparam int SPEED_W        = 10;

	localparam int BI_W   = 32;
	localparam int BU_W   = 33;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 16;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W  = BI_W + BU_W;

	localparam int Q_DEPTH = 2;

	localparam int IN_DATA_W  = 8 * FIELD_W + 2 * FRAME_W;
	localparam int OUT_PAY_W  = 4 * FIELD_W + FRAME_W + 2 * VEL_W;
	localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;

	localparam int APB_ADDR_W = 4;
	localparam int REG_IDX_W  = 2;
	localparam int APB_DATA_W = 32;

	localparam logic [REG_IDX_W-1:0] REG_IOU_THRESHOLD   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_GAP_LIMIT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SPEED_MULT      = 2'd2;

	localparam logic [THR_W-1:0]   IOU_THRESHOLD_RST   = 16'd32768;
	localparam logic [LIMIT_W-1:0] FRAME_GAP_LIMIT_RST = 16'd10;
	localparam logic [SPEED_W-1:0] SPEED_MULT_RST      = 10'd100;

	typedef struct packed {
		logic [THR_W-1:0]   iou_threshold;
		logic [LIMIT_W-1:0] frame_gap_limit;
		logic [SPEED_W-1:0] speed_multiplier;
	} tbim_cfg_t;

	typedef struct packed {
		logic               score;
		logic               last;
		logic [FIELD_W-1:0] dx;
		logic [FIELD_W-1:0] dy;
		logic [FIELD_W-1:0] cx;
		logic [FIELD_W-1:0] cy;
		logic [FIELD_W-1:0] cw;
		logic [FIELD_W-1:0] ch;
		logic [FIELD_W-1:0] rx;
		logic [FIELD_W-1:0] ry;
		logic [FIELD_W-1:0] rw;
		logic [FIELD_W-1:0] rh;
		logic [FRAME_W-1:0] gap;
	} tbim_item_t;

endpackage

// ===== design/tbim_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tbim_div #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== design/tbim_front.sv =====
// Input side: masks and classifies each item and queues it for the back end.
module tbim_front #(
	parameter int COORD_BITS = tbim_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tbim_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  logic                               s_axis_tlast,
	input  logic                               s_axis_tuser,
	output logic                               item_valid,
	output tbim_pkg::tbim_item_t               item,
	input  logic                               item_pop
);

	localparam int FW    = tbim_pkg::FIELD_W;
	localparam int GW    = tbim_pkg::FRAME_W;
	localparam int CW    = (COORD_BITS < FW) ? COORD_BITS : FW;
	localparam int DEPTH = tbim_pkg::Q_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [FW-1:0] cx, cy, cw, ch, rx, ry, rw, rh;
	logic [GW-1:0] ref_frame, cur_frame;
	logic [FW:0]   lx, ly, hx, hy, ce, cb, re, rb;
	logic          overlap;
	logic          push;
	tbim_pkg::tbim_item_t entry;

	tbim_pkg::tbim_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign cx = FW'(s_axis_tdata[0*FW +: CW]);
	assign cy = FW'(s_axis_tdata[1*FW +: CW]);
	assign cw = FW'(s_axis_tdata[2*FW +: CW]);
	assign ch = FW'(s_axis_tdata[3*FW +: CW]);
	assign rx = FW'(s_axis_tdata[4*FW +: CW]);
	assign ry = FW'(s_axis_tdata[5*FW +: CW]);
	assign rw = FW'(s_axis_tdata[6*FW +: CW]);
	assign rh = FW'(s_axis_tdata[7*FW +: CW]);
	assign ref_frame = s_axis_tdata[8*FW +: GW];
	assign cur_frame = s_axis_tdata[8*FW+GW +: GW];

	always_comb begin
		ce = (FW+1)'(cx) + (FW+1)'(cw);
		re = (FW+1)'(rx) + (FW+1)'(rw);
		cb = (FW+1)'(cy) + (FW+1)'(ch);
		rb = (FW+1)'(ry) + (FW+1)'(rh);
		lx = (cx > rx) ? (FW+1)'(cx) : (FW+1)'(rx);
		ly = (cy > ry) ? (FW+1)'(cy) : (FW+1)'(ry);
		hx = (ce < re) ? ce : re;
		hy = (cb < rb) ? cb : rb;
		overlap = (lx <= hx) && (ly <= hy);

		entry.score = s_axis_tuser && overlap;
		entry.last  = s_axis_tlast;
		entry.dx    = FW'(hx - lx);
		entry.dy    = FW'(hy - ly);
		entry.cx    = cx;
		entry.cy    = cy;
		entry.cw    = cw;
		entry.ch    = ch;
		entry.rx    = rx;
		entry.ry    = ry;
		entry.rw    = rw;
		entry.rh    = rh;
		entry.gap   = cur_frame - ref_frame;
	end

	assign s_axis_tready = count_q != CNT_W'(DEPTH);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign item_valid    = count_q != '0;
	assign item          = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (item_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !item_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && item_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

endmodule

// ===== design/tbim_back.sv =====
// Back end: scores queued items with a shared multiplier and builds the result.
module tbim_back #(
	parameter int COORD_BITS = tbim_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	input  tbim_pkg::tbim_item_t              item,
	output logic                              item_pop,
	input  tbim_pkg::tbim_cfg_t               cfg,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [tbim_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tuser
);

	localparam int FW    = tbim_pkg::FIELD_W;
	localparam int CW    = (COORD_BITS < FW) ? COORD_BITS : FW;
	localparam int AW    = tbim_pkg::MUL_A_W;
	localparam int BW    = tbim_pkg::MUL_B_W;
	localparam int PW    = tbim_pkg::PROD_W;
	localparam int ACW   = tbim_pkg::ACC_W;
	localparam int IW    = tbim_pkg::BI_W;
	localparam int UW    = tbim_pkg::BU_W;
	localparam int GW    = tbim_pkg::FRAME_W;
	localparam int VW    = tbim_pkg::VEL_W;
	localparam int TW    = tbim_pkg::THR_W;
	localparam int NUM_W = CW + tbim_pkg::SPEED_W;
	localparam int PAD_W = tbim_pkg::OUT_DATA_W - tbim_pkg::OUT_PAY_W;
	localparam int SCORE_STEPS = 8;
	localparam int STEP_W = $clog2(SCORE_STEPS);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_SCORE = 8'b00000010,
		ST_THR   = 8'b00000100,
		ST_CHK   = 8'b00001000,
		ST_VMUL  = 8'b00010000,
		ST_VLOAD = 8'b00100000,
		ST_VDIV  = 8'b01000000,
		ST_EMIT  = 8'b10000000
	} tbim_state_t;

	tbim_state_t          state_q;
	tbim_pkg::tbim_item_t cur_q;
	logic [STEP_W-1:0]    step_q;
	logic                 axis_q;

	logic [PW-1:0]  prod_q;
	logic [IW-1:0]  inter_q;
	logic [UW-1:0]  area_q;
	logic [UW-1:0]  uni_q;
	logic [ACW-1:0] lhs_q;
	logic [ACW-1:0] rhs_q;

	logic [IW-1:0]  best_inter_q;
	logic [UW-1:0]  best_union_q;
	logic [FW-1:0]  best_x_q, best_y_q, best_w_q, best_h_q;

	logic           matched_q;
	logic [FW-1:0]  mag_x_q, mag_y_q;
	logic           neg_x_q, neg_y_q;
	logic [VW-1:0]  vel_x_q, vel_y_q;

	logic                              out_valid_q;
	logic [tbim_pkg::OUT_DATA_W-1:0]   out_data_q;
	logic                              out_user_q;

	logic [AW-1:0]  mul_a;
	logic [BW-1:0]  mul_b;
	logic           better;
	logic           pass;
	logic           div_start;
	logic           div_done;
	logic [NUM_W-1:0] div_quo;
	logic [VW-1:0]  vel_now;
	logic           out_free;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SCORE: begin
				case (step_q)
					3'd0: begin
						mul_a = AW'(cur_q.dx);
						mul_b = cur_q.dy;
					end
					3'd1: begin
						mul_a = AW'(cur_q.cw);
						mul_b = cur_q.ch;
					end
					3'd2: begin
						mul_a = AW'(cur_q.rw);
						mul_b = cur_q.rh;
					end
					3'd3: begin
						mul_a = best_union_q;
						mul_b = inter_q[BW-1:0];
					end
					3'd4: begin
						mul_a = best_union_q;
						mul_b = inter_q[IW-1:BW];
					end
					3'd5: begin
						mul_a = uni_q;
						mul_b = best_inter_q[BW-1:0];
					end
					3'd6: begin
						mul_a = uni_q;
						mul_b = best_inter_q[IW-1:BW];
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			ST_THR: begin
				mul_a = best_union_q;
				mul_b = BW'(cfg.iou_threshold);
			end
			ST_VMUL: begin
				mul_a = AW'(axis_q ? mag_y_q : mag_x_q);
				mul_b = BW'(cfg.speed_multiplier);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign better = (uni_q != '0) && (lhs_q > (rhs_q + (ACW'(prod_q) << BW)));
	assign pass   = (PW'({best_inter_q, {TW{1'b0}}}) > prod_q) &&
	                (cur_q.gap < GW'(cfg.frame_gap_limit));
	assign item_pop  = (state_q == ST_IDLE) && item_valid;
	assign div_start = state_q == ST_VLOAD;
	assign out_free  = !out_valid_q || m_axis_tready;

	always_comb begin
		if (axis_q ? neg_y_q : neg_x_q) begin
			vel_now = VW'(0) - VW'(div_quo);
		end else begin
			vel_now = VW'(div_quo);
		end
	end

	tbim_div #(
		.NUM_W(NUM_W),
		.DEN_W(GW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (prod_q[NUM_W-1:0]),
		.den   (cur_q.gap),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			axis_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			best_inter_q <= '0;
			best_union_q <= UW'(1);
			best_x_q     <= '0;
			best_y_q     <= '0;
			best_w_q     <= '0;
			best_h_q     <= '0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (item_valid) begin
						if (item.score) begin
							state_q <= ST_SCORE;
						end else if (item.last) begin
							state_q <= ST_THR;
						end
					end
				end
				ST_SCORE: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SCORE_STEPS - 1)) begin
						if (better) begin
							best_inter_q <= inter_q;
							best_union_q <= uni_q;
							best_x_q     <= cur_q.cx;
							best_y_q     <= cur_q.cy;
							best_w_q     <= cur_q.cw;
							best_h_q     <= cur_q.ch;
						end
						state_q <= cur_q.last ? ST_THR : ST_IDLE;
					end
				end
				ST_THR: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					axis_q <= 1'b0;
					if (pass && (cur_q.gap != '0)) begin
						state_q <= ST_VMUL;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_VMUL: begin
					state_q <= ST_VLOAD;
				end
				ST_VLOAD: begin
					state_q <= ST_VDIV;
				end
				ST_VDIV: begin
					if (div_done) begin
						if (axis_q) begin
							state_q <= ST_EMIT;
						end else begin
							axis_q  <= 1'b1;
							state_q <= ST_VMUL;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						best_inter_q <= '0;
						best_union_q <= UW'(1);
						best_x_q     <= '0;
						best_y_q     <= '0;
						best_w_q     <= '0;
						best_h_q     <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
		if (item_pop) begin
			cur_q <= item;
		end
		if (state_q == ST_SCORE) begin
			case (step_q)
				3'd1: inter_q <= prod_q[IW-1:0];
				3'd2: area_q  <= prod_q[UW-1:0];
				3'd3: uni_q   <= area_q + prod_q[UW-1:0] - UW'(inter_q);
				3'd4: lhs_q   <= ACW'(prod_q);
				3'd5: lhs_q   <= lhs_q + (ACW'(prod_q) << BW);
				3'd6: rhs_q   <= ACW'(prod_q);
				default: begin
				end
			endcase
		end
		if (state_q == ST_CHK) begin
			matched_q <= pass;
			neg_x_q   <= best_x_q < cur_q.rx;
			neg_y_q   <= best_y_q < cur_q.ry;
			mag_x_q   <= (best_x_q < cur_q.rx) ? cur_q.rx - best_x_q : best_x_q - cur_q.rx;
			mag_y_q   <= (best_y_q < cur_q.ry) ? cur_q.ry - best_y_q : best_y_q - cur_q.ry;
			vel_x_q   <= '0;
			vel_y_q   <= '0;
		end
		if ((state_q == ST_VDIV) && div_done) begin
			if (axis_q) begin
				vel_y_q <= vel_now;
			end else begin
				vel_x_q <= vel_now;
			end
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_user_q <= matched_q;
			if (matched_q) begin
				out_data_q <= {{PAD_W{1'b0}}, vel_y_q, vel_x_q, cur_q.gap,
				               best_h_q, best_w_q, best_y_q, best_x_q};
			end else begin
				out_data_q <= {{PAD_W{1'b0}}, {(2*VW){1'b0}}, cur_q.gap, {(4*FW){1'b0}}};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

// ===== design/track_best_iou_match_update.sv =====
// Top level of the track best-IoU match update block.
// Candidate items for one track enter on the s_axis stream; each repeats the
// track's last box and frame. The item with tlast high closes the track and
// yields exactly one result item on m_axis; other items yield none.
// Registers on the APB port: 0x0 IoU threshold (Q0.16), 0x4 frame gap limit,
// 0x8 speed multiplier. Write them only while no track is in flight.
// A scored candidate needs seven products on the single 33x16 multiplier and
// the final compare. A closing item that is matched with a nonzero gap also
// runs the one-bit-per-cycle divider (NUM_W = min(COORD_BITS,16)+10) once
// per velocity axis.
// A two-entry queue sits between input and scoring, so input is taken while
// the back end works. The result sits in an output register; while it is
// not taken, the next track's candidates are still scored, and the block
// holds only when a further result is ready.
// Reset clears the queue, the running best and the output valid, and loads
// the register defaults (threshold 0.5, gap limit 10, multiplier 100).
module track_best_iou_match_update #(
	parameter int COORD_BITS = tbim_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// cand_x, cand_y, cand_w, cand_h, ref_x, ref_y, ref_w, ref_h, ref_frame, cur_frame
	input  logic [tbim_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tlast,
	// cand_valid
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// new_x, new_y, new_w, new_h, frame_gap, vel_x, vel_y, zero pad
	output logic [tbim_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// matched
	output logic                                m_axis_tuser,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tbim_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [tbim_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [tbim_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int DW = tbim_pkg::APB_DATA_W;
	localparam int XW = tbim_pkg::REG_IDX_W;

	tbim_pkg::tbim_cfg_t  cfg_q;
	tbim_pkg::tbim_item_t item;
	logic                 item_valid;
	logic                 item_pop;
	logic                 wr_en;
	logic [XW-1:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[XW+1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iou_threshold    <= tbim_pkg::IOU_THRESHOLD_RST;
			cfg_q.frame_gap_limit  <= tbim_pkg::FRAME_GAP_LIMIT_RST;
			cfg_q.speed_multiplier <= tbim_pkg::SPEED_MULT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				tbim_pkg::REG_IOU_THRESHOLD:
					cfg_q.iou_threshold <= pwdata[tbim_pkg::THR_W-1:0];
				tbim_pkg::REG_FRAME_GAP_LIMIT:
					cfg_q.frame_gap_limit <= pwdata[tbim_pkg::LIMIT_W-1:0];
				tbim_pkg::REG_SPEED_MULT:
					cfg_q.speed_multiplier <= pwdata[tbim_pkg::SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tbim_pkg::REG_IOU_THRESHOLD:   prdata = DW'(cfg_q.iou_threshold);
			tbim_pkg::REG_FRAME_GAP_LIMIT: prdata = DW'(cfg_q.frame_gap_limit);
			tbim_pkg::REG_SPEED_MULT:      prdata = DW'(cfg_q.speed_multiplier);
			default:                       prdata = '0;
		endcase
	end

	tbim_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tuser (s_axis_tuser),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop)
	);

	tbim_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop),
		.cfg          (cfg_q),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	a_unmatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			m_axis_tdata[63:0] == '0 && m_axis_tdata[149:96] == '0)
		else $error("unmatched result carries a box or velocity");

	a_zero_gap_still: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[95:64] == '0 |-> m_axis_tdata[149:96] == '0)
		else $error("zero frame gap with nonzero velocity");

	a_match_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[95:64] < tbim_pkg::FRAME_W'(cfg_q.frame_gap_limit))
		else $error("match reported with frame gap at or over the limit");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> item_valid)
		else $error("back end took an item from an empty queue");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the track best-IoU match update block: directed table, random tracks, scoreboard.
module tb_top;

	localparam int FIELD_W     = tbim_pkg::FIELD_W;
	localparam int FRAME_W     = tbim_pkg::FRAME_W;
	localparam int VEL_W       = tbim_pkg::VEL_W;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 120;
	localparam logic [63:0] VEL_SAT = 64'd67108863;

	typedef struct packed {
		logic               cand_valid;
		logic [FIELD_W-1:0] cx;
		logic [FIELD_W-1:0] cy;
		logic [FIELD_W-1:0] cw;
		logic [FIELD_W-1:0] ch;
		logic [FIELD_W-1:0] rx;
		logic [FIELD_W-1:0] ry;
		logic [FIELD_W-1:0] rw;
		logic [FIELD_W-1:0] rh;
		logic [FRAME_W-1:0] ref_frame;
		logic [FRAME_W-1:0] cur_frame;
		logic               last;
	} cand_item_t;

	typedef struct packed {
		logic                    matched;
		logic [FIELD_W-1:0]      nx;
		logic [FIELD_W-1:0]      ny;
		logic [FIELD_W-1:0]      nw;
		logic [FIELD_W-1:0]      nh;
		logic [FRAME_W-1:0]      gap;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
	} match_res_t;

	typedef struct packed {
		cand_item_t item;
		logic       typed;
		match_res_t res;
	} dir_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               s_axis_tvalid;
	logic                               s_axis_tready;
	logic [tbim_pkg::IN_DATA_W-1:0]     s_axis_tdata;
	logic                               s_axis_tlast;
	logic                               s_axis_tuser;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready;
	logic [tbim_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
	logic                               m_axis_tuser;
	logic                               psel;
	logic                               penable;
	logic                               pwrite;
	logic [tbim_pkg::APB_ADDR_W-1:0]    paddr;
	logic [tbim_pkg::APB_DATA_W-1:0]    pwdata;
	logic [tbim_pkg::APB_DATA_W-1:0]    prdata;
	logic                               pready;

	track_best_iou_match_update uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tbim_pkg::tbim_cfg_t regs;
	logic [63:0]         best_inter;
	logic [63:0]         best_union;
	logic [FIELD_W-1:0]  best_x, best_y, best_w, best_h;
	match_res_t          pending_matches[$];
	dir_row_t            dir_tab[$];
	int                  mismatch_cnt;
	int                  cycles;
	int                  burst_left;
	int                  stall_left;
	int                  stall_mode;

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 80);
		end
		stall_left = stall_left - 1;
		case (stall_mode)
			0: begin
				m_axis_tready = 1'b1;
			end
			1: begin
				m_axis_tready = 1'($urandom_range(0, 1));
			end
			2: begin
				m_axis_tready = (cycles % 4 == 0);
			end
			default: begin
				m_axis_tready = ($urandom_range(0, 9) == 0);
			end
		endcase
	end

	function automatic bit cross_gt(input logic [63:0] a, b, c, d);
		logic [127:0] p;
		logic [127:0] q;
		p = 128'(a) * 128'(b);
		q = 128'(c) * 128'(d);
		return p > q;
	endfunction

	function automatic logic [VEL_W-1:0] scaled_vel(input logic [FIELD_W-1:0] a, b,
							input logic [FRAME_W-1:0] gap);
		logic [63:0] mag;
		logic [63:0] q;
		logic        neg;
		neg = a < b;
		mag = neg ? 64'(b) - 64'(a) : 64'(a) - 64'(b);
		if (gap == 0) begin
			return '0;
		end
		q = (mag * 64'(regs.speed_multiplier)) / 64'(gap);
		if (q > VEL_SAT) begin
			q = VEL_SAT;
		end
		if (neg) begin
			q = -q;
		end
		return q[VEL_W-1:0];
	endfunction

	function automatic bit assoc_update(input cand_item_t it, output match_res_t r);
		logic [63:0]        lx, ly, ce, re, cb, rb, hx, hy, inter, uni;
		logic [FRAME_W-1:0] gap;
		logic               hit;
		r = '0;
		if (it.cand_valid) begin
			lx = (it.cx > it.rx) ? 64'(it.cx) : 64'(it.rx);
			ly = (it.cy > it.ry) ? 64'(it.cy) : 64'(it.ry);
			ce = 64'(it.cx) + 64'(it.cw);
			re = 64'(it.rx) + 64'(it.rw);
			cb = 64'(it.cy) + 64'(it.ch);
			rb = 64'(it.ry) + 64'(it.rh);
			hx = (ce < re) ? ce : re;
			hy = (cb < rb) ? cb : rb;
			if (lx <= hx && ly <= hy) begin
				inter = (hx - lx) * (hy - ly);
				uni = 64'(it.cw) * 64'(it.ch) + 64'(it.rw) * 64'(it.rh) - inter;
				if (uni != 0 && cross_gt(inter, best_union, best_inter, uni)) begin
					best_inter = inter;
					best_union = uni;
					best_x = it.cx;
					best_y = it.cy;
					best_w = it.cw;
					best_h = it.ch;
				end
			end
		end
		if (!it.last) begin
			return 1'b0;
		end
		gap = it.cur_frame - it.ref_frame;
		hit = cross_gt(best_inter, 64'd65536, 64'(regs.iou_threshold), best_union) &&
			(gap < FRAME_W'(regs.frame_gap_limit));
		r.matched = hit;
		r.gap = gap;
		if (hit) begin
			r.nx = best_x;
			r.ny = best_y;
			r.nw = best_w;
			r.nh = best_h;
			r.vx = scaled_vel(best_x, it.rx, gap);
			r.vy = scaled_vel(best_y, it.ry, gap);
		end
		best_inter = 0;
		best_union = 1;
		best_x = '0;
		best_y = '0;
		best_w = '0;
		best_h = '0;
		return 1'b1;
	endfunction

	function automatic cand_item_t mk_item(input bit v, input int cx, cy, cw, ch,
					       input int rx, ry, rw, rh,
					       input logic [FRAME_W-1:0] rf, cf, input bit last);
		cand_item_t it;
		it.cand_valid = v;
		it.cx = FIELD_W'(cx);
		it.cy = FIELD_W'(cy);
		it.cw = FIELD_W'(cw);
		it.ch = FIELD_W'(ch);
		it.rx = FIELD_W'(rx);
		it.ry = FIELD_W'(ry);
		it.rw = FIELD_W'(rw);
		it.rh = FIELD_W'(rh);
		it.ref_frame = rf;
		it.cur_frame = cf;
		it.last = last;
		return it;
	endfunction

	function automatic match_res_t mk_res(input bit m, input int nx, ny, nw, nh,
					      input logic [FRAME_W-1:0] gap, input int vx, vy);
		match_res_t r;
		r.matched = m;
		r.nx = FIELD_W'(nx);
		r.ny = FIELD_W'(ny);
		r.nw = FIELD_W'(nw);
		r.nh = FIELD_W'(nh);
		r.gap = gap;
		r.vx = VEL_W'(vx);
		r.vy = VEL_W'(vy);
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] jitter(input logic [FIELD_W-1:0] w);
		int s;
		s = int'(w) / 2 + 1;
		return FIELD_W'(int'($urandom_range(0, 2 * s)) - s);
	endfunction

	task automatic add_row(input dir_row_t row);
		dir_tab.insert(dir_tab.size(), row);
	endtask

	task automatic note_mismatch(input string what, input match_res_t want, got);
		mismatch_cnt = mismatch_cnt + 1;
		if (mismatch_cnt <= 10) begin
			$display("%s at cycle %0d", what, cycles);
			$display("  expected m=%0d box=%0d,%0d,%0d,%0d gap=%0d vel=%0d,%0d",
				 want.matched, want.nx, want.ny, want.nw, want.nh, want.gap,
				 want.vx, want.vy);
			$display("  actual   m=%0d box=%0d,%0d,%0d,%0d gap=%0d vel=%0d,%0d",
				 got.matched, got.nx, got.ny, got.nw, got.nh, got.gap,
				 got.vx, got.vy);
		end
	endtask

	always @(posedge clk) begin
		match_res_t got;
		match_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.matched = m_axis_tuser;
			got.nx = m_axis_tdata[15:0];
			got.ny = m_axis_tdata[31:16];
			got.nw = m_axis_tdata[47:32];
			got.nh = m_axis_tdata[63:48];
			got.gap = m_axis_tdata[95:64];
			got.vx = m_axis_tdata[122:96];
			got.vy = m_axis_tdata[149:123];
			if (pending_matches.size() == 0) begin
				note_mismatch("result with nothing pending", '0, got);
			end else begin
				want = pending_matches.pop_front();
				if (got !== want) begin
					note_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	task automatic send_item(input cand_item_t it, input logic typed, input match_res_t typed_res);
		match_res_t r;
		int         idle;
		@(negedge clk);
		if (burst_left == 0) begin
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (idle > 0) begin
				s_axis_tvalid = 1'b0;
				repeat (idle) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 8);
		end
		burst_left = burst_left - 1;
		s_axis_tdata = {it.cur_frame, it.ref_frame, it.rh, it.rw, it.ry, it.rx,
				it.ch, it.cw, it.cy, it.cx};
		s_axis_tuser = it.cand_valid;
		s_axis_tlast = it.last;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (assoc_update(it, r)) begin
			pending_matches.insert(pending_matches.size(), typed ? typed_res : r);
		end
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		burst_left = 0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic [tbim_pkg::REG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			tbim_pkg::REG_IOU_THRESHOLD: begin
				regs.iou_threshold = val[tbim_pkg::THR_W-1:0];
			end
			tbim_pkg::REG_FRAME_GAP_LIMIT: begin
				regs.frame_gap_limit = val[tbim_pkg::LIMIT_W-1:0];
			end
			default: begin
				regs.speed_multiplier = val[tbim_pkg::SPEED_W-1:0];
			end
		endcase
	endtask

	task automatic run_tracks(input int target);
		int                 sent, len, mode, k;
		logic [FIELD_W-1:0] rx, ry, rw, rh;
		logic [FRAME_W-1:0] rf, gap;
		cand_item_t         it;
		sent = 0;
		while (sent < target) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
			mode = $urandom_range(0, 9);
			if (mode < 7) begin
				rx = FIELD_W'($urandom_range(0, 3000));
				ry = FIELD_W'($urandom_range(0, 3000));
				rw = FIELD_W'($urandom_range(1, 300));
				rh = FIELD_W'($urandom_range(1, 300));
			end else if (mode < 9) begin
				rx = FIELD_W'($urandom);
				ry = FIELD_W'($urandom);
				rw = FIELD_W'($urandom);
				rh = FIELD_W'($urandom);
			end else begin
				rx = 16'hFFFF - FIELD_W'($urandom_range(0, 200));
				ry = 16'hFFFF - FIELD_W'($urandom_range(0, 200));
				rw = FIELD_W'($urandom_range(0, 400));
				rh = FIELD_W'($urandom_range(0, 400));
			end
			rf = $urandom;
			k = $urandom_range(0, 19);
			if (k < 12) begin
				gap = $urandom_range(0, 12);
			end else if (k < 15) begin
				gap = FRAME_W'(regs.frame_gap_limit) + $urandom_range(0, 2) - 1;
			end else begin
				gap = $urandom;
			end
			for (int i = 0; i < len; i++) begin
				it.rx = rx;
				it.ry = ry;
				it.rw = rw;
				it.rh = rh;
				it.ref_frame = rf;
				it.cur_frame = rf + gap;
				it.last = (i == len - 1);
				k = $urandom_range(0, 19);
				it.cand_valid = (k >= 3);
				if (k < 3 || k >= 18) begin
					it.cx = FIELD_W'($urandom);
					it.cy = FIELD_W'($urandom);
					it.cw = FIELD_W'($urandom);
					it.ch = FIELD_W'($urandom);
				end else if (k < 6) begin
					it.cx = rx;
					it.cy = ry;
					it.cw = rw;
					it.ch = rh;
				end else begin
					it.cx = rx + jitter(rw);
					it.cy = ry + jitter(rh);
					it.cw = rw + jitter(rw);
					it.ch = rh + jitter(rh);
				end
				if ($urandom_range(0, 19) == 0) begin
					it.rx = FIELD_W'($urandom);
					it.ry = FIELD_W'($urandom);
					it.rw = FIELD_W'($urandom);
					it.rh = FIELD_W'($urandom);
				end
				send_item(it, 1'b0, '0);
				sent = sent + 1;
			end
		end
	endtask

	initial begin
		logic [31:0] phase_cfg[6][3];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatch_cnt = 0;
		cycles = 0;
		burst_left = 0;
		stall_left = 0;
		stall_mode = 0;
		regs.iou_threshold = tbim_pkg::IOU_THRESHOLD_RST;
		regs.frame_gap_limit = tbim_pkg::FRAME_GAP_LIMIT_RST;
		regs.speed_multiplier = tbim_pkg::SPEED_MULT_RST;
		best_inter = 0;
		best_union = 1;
		best_x = '0;
		best_y = '0;
		best_w = '0;
		best_h = '0;

		// empty list, identical box, touching, far apart, zero union
		add_row({mk_item(0, 1, 2, 3, 4, 10, 10, 10, 10, 5, 7, 1), 1'b1,
			 mk_res(0, 0, 0, 0, 0, 2, 0, 0)});
		add_row({mk_item(1, 100, 100, 20, 20, 100, 100, 20, 20, 0, 0, 1), 1'b1,
			 mk_res(1, 100, 100, 20, 20, 0, 0, 0)});
		add_row({mk_item(1, 120, 100, 20, 20, 100, 100, 20, 20, 4, 7, 1), 1'b1,
			 mk_res(0, 0, 0, 0, 0, 3, 0, 0)});
		add_row({mk_item(1, 0, 0, 5, 5, 1000, 1000, 5, 5, 0, 1, 1), 1'b1,
			 mk_res(0, 0, 0, 0, 0, 1, 0, 0)});
		add_row({mk_item(1, 50, 50, 0, 0, 50, 50, 0, 0, 0, 1, 1), 1'b1,
			 mk_res(0, 0, 0, 0, 0, 1, 0, 0)});
		// frame counter wrap, gap equal to limit, ratio exactly at threshold
		add_row({mk_item(1, 300, 40, 8, 8, 300, 40, 8, 8, 32'hFFFF_FFFF, 2, 1),
			 1'b1, mk_res(1, 300, 40, 8, 8, 3, 0, 0)});
		add_row({mk_item(1, 300, 40, 8, 8, 300, 40, 8, 8, 100, 110, 1), 1'b1,
			 mk_res(0, 0, 0, 0, 0, 10, 0, 0)});
		add_row({mk_item(1, 10, 0, 30, 10, 0, 0, 30, 10, 0, 1, 1), 1'b1,
			 mk_res(0, 0, 0, 0, 0, 1, 0, 0)});
		// tie keeps the first candidate
		add_row({mk_item(1, 110, 100, 40, 40, 100, 100, 40, 40, 10, 12, 0),
			 1'b0, match_res_t'('0)});
		add_row({mk_item(0, 65535, 65535, 65535, 65535, 100, 100, 40, 40, 10, 12, 0),
			 1'b0, match_res_t'('0)});
		add_row({mk_item(1, 90, 100, 40, 40, 100, 100, 40, 40, 10, 12, 0),
			 1'b0, match_res_t'('0)});
		add_row({mk_item(1, 130, 130, 40, 40, 100, 100, 40, 40, 10, 12, 1),
			 1'b0, match_res_t'('0)});
		add_row({mk_item(1, 190, 195, 50, 50, 200, 200, 50, 50, 7, 10, 1),
			 1'b0, match_res_t'('0)});
		add_row({mk_item(1, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535,
				 0, 1, 1), 1'b1, mk_res(1, 65535, 65535, 65535, 65535, 1, 0, 0)});
		add_row({mk_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1,
			 mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
		add_row({mk_item(1, 16384, 0, 65535, 65535, 0, 0, 65535, 65535,
				 32'h8000_0000, 32'h8000_0001, 1), 1'b0, match_res_t'('0)});
		// velocity taken against the reference on the closing item
		add_row({mk_item(1, 500, 500, 100, 100, 500, 500, 100, 100, 0, 0, 0),
			 1'b0, match_res_t'('0)});
		add_row({mk_item(0, 0, 0, 0, 0, 520, 480, 100, 100, 0, 4, 1), 1'b0,
			 match_res_t'('0)});

		phase_cfg[0] = '{32'd0, 32'd65535, 32'd1023};
		phase_cfg[1] = '{32'd65535, 32'd1, 32'd1};
		phase_cfg[2] = '{32'd16384, 32'd20, 32'd0};
		phase_cfg[3] = '{32'd40000, 32'd0, 32'd512};
		phase_cfg[4] = '{32'($urandom_range(0, 65535)), 32'($urandom_range(0, 64)),
				 32'($urandom_range(1, 1023))};
		phase_cfg[5] = '{32'($urandom_range(0, 65535)), 32'($urandom_range(0, 64)),
				 32'($urandom_range(1, 1023))};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
		end

		for (int p = 0; p < 6; p++) begin
			drain_and_settle();
			reg_write(tbim_pkg::REG_IOU_THRESHOLD, phase_cfg[p][0]);
			reg_write(tbim_pkg::REG_FRAME_GAP_LIMIT, phase_cfg[p][1]);
			reg_write(tbim_pkg::REG_SPEED_MULT, phase_cfg[p][2]);
			run_tracks(88);
		end
		drain_and_settle();

		if (mismatch_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ===== track_best_iou_match_update.f =====
design/tbim_pkg.sv
design/tbim_div.sv
design/tbim_front.sv
design/tbim_back.sv
design/track_best_iou_match_update.sv
tb/tb_top.sv
